// ----- rtl/slqt_pkg.sv -----
// Package for the STA/LTA quake trigger: payload structs, register indexes,
// field widths and reset values. No dependencies.
package slqt_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int TIME_W      = 63;
    localparam int DEV_SUM_W   = 34;
    localparam int RATIO_W     = 8;
    localparam int THR_W       = 4;
    localparam int HIT_W       = 5;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_RATIO_Q4          = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_THRESHOLD = 8'd1;

    localparam logic [RATIO_W-1:0]   RATIO_Q4_RESET  = 8'd48;
    localparam logic [THR_W-1:0]     THRESHOLD_RESET = 4'd3;
    localparam logic [DEV_SUM_W-1:0] DEV_SUM_MAX     = {DEV_SUM_W{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_z;
        logic [TIME_W-1:0]          time_ms;
    } quake_in_t;

    typedef struct packed {
        logic [TIME_W-1:0]    event_time_ms;
        logic [DEV_SUM_W-1:0] short_dev_sum;
        logic [DEV_SUM_W-1:0] long_dev_sum;
    } quake_out_t;

    // sequencer -> deviation accumulator
    typedef struct packed {
        logic clear;
        logic data_valid;
        logic in_short;
    } dev_ctrl_t;

endpackage

// ----- rtl/slqt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module slqt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 500
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/slqt_dev_acc.sv -----
// Deviation unit: |L*z - window_sum| per ring entry, saturating long and
// short accumulators. Depends on slqt_pkg.
module slqt_dev_acc
    import slqt_pkg::*;
#(
    parameter int LONG_WINDOW = 500,
    parameter int SUM_W       = 25
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dev_ctrl_t               ctrl,
    input  logic [SAMPLE_W-1:0]     rd_data,
    input  logic signed [SUM_W-1:0] window_sum,
    output logic                    busy,
    output logic [DEV_SUM_W-1:0]    short_sum,
    output logic [DEV_SUM_W-1:0]    long_sum
);

    localparam int DEV_W = SUM_W + 1;
    localparam int ACC_W = ((DEV_W > DEV_SUM_W) ? DEV_W : DEV_SUM_W) + 1;
    localparam logic signed [DEV_W-1:0] L_S = DEV_W'(LONG_WINDOW);

    logic signed [DEV_W-1:0] z_ext;
    logic signed [DEV_W-1:0] sum_ext;
    logic signed [DEV_W-1:0] lz;
    logic signed [DEV_W-1:0] diff;
    logic [DEV_W-1:0]        dev_abs;

    logic [DEV_W-1:0]     dev_reg;
    logic                 dev_vld_reg;
    logic                 dev_short_reg;
    logic [DEV_SUM_W-1:0] long_acc_reg, long_acc_next;
    logic [DEV_SUM_W-1:0] short_acc_reg, short_acc_next;
    logic [ACC_W-1:0]     long_add;
    logic [ACC_W-1:0]     short_add;

    always_comb
    begin
        z_ext   = {{(DEV_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
        sum_ext = {window_sum[SUM_W-1], window_sum};
        lz      = z_ext * L_S;
        diff    = lz - sum_ext;
        dev_abs = diff[DEV_W-1] ? DEV_W'(-diff) : DEV_W'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_vld_reg   <= 1'b0;
            dev_short_reg <= 1'b0;
        end
        else
        begin
            dev_vld_reg   <= ctrl.data_valid;
            dev_short_reg <= ctrl.in_short;
        end
    end

    always_ff @(posedge clk)
    begin
        dev_reg <= dev_abs;
    end

    // terms are never negative, so clamping at each step equals clamping at the end
    always_comb
    begin
        long_add       = ACC_W'(long_acc_reg) + ACC_W'(dev_reg);
        short_add      = ACC_W'(short_acc_reg) + ACC_W'(dev_reg);
        long_acc_next  = long_acc_reg;
        short_acc_next = short_acc_reg;
        if (ctrl.clear)
        begin
            long_acc_next  = '0;
            short_acc_next = '0;
        end
        else if (dev_vld_reg)
        begin
            long_acc_next = (long_add[ACC_W-1:DEV_SUM_W] != '0) ? DEV_SUM_MAX
                                                                : long_add[DEV_SUM_W-1:0];
            if (dev_short_reg)
            begin
                short_acc_next = (short_add[ACC_W-1:DEV_SUM_W] != '0)
                                 ? DEV_SUM_MAX : short_add[DEV_SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_acc_reg  <= '0;
            short_acc_reg <= '0;
        end
        else
        begin
            long_acc_reg  <= long_acc_next;
            short_acc_reg <= short_acc_next;
        end
    end

    assign busy      = dev_vld_reg;
    assign long_sum  = long_acc_reg;
    assign short_sum = short_acc_reg;

endmodule

// ----- rtl/slqt_ratio_cmp.sv -----
// Ratio test st*L*16 > lt*S*ratio by shift-and-add over the constant bits.
// Depends on slqt_pkg.
module slqt_ratio_cmp
    import slqt_pkg::*;
#(
    parameter int LONG_WINDOW  = 500,
    parameter int SHORT_WINDOW = 150
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DEV_SUM_W-1:0] st,
    input  logic [DEV_SUM_W-1:0] lt,
    input  logic [RATIO_W-1:0]   ratio,
    output logic                 done,
    output logic                 greater
);

    localparam int SHORT_LEN = (SHORT_WINDOW < LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
    localparam int CW  = $clog2(LONG_WINDOW + 1);
    localparam int MW  = CW + RATIO_W;
    localparam int PW  = DEV_SUM_W + MW;
    localparam int NW  = $clog2(MW + 1);
    localparam logic [MW-1:0] KL = MW'(LONG_WINDOW * 16);
    localparam logic [MW-1:0] KS = MW'(SHORT_LEN);

    logic          busy_reg;
    logic [NW-1:0] cnt_reg;
    logic [MW-1:0] kl_reg;
    logic [MW-1:0] kr_reg;
    logic [PW-1:0] a_reg;
    logic [PW-1:0] b_reg;
    logic [PW-1:0] lhs_reg;
    logic [PW-1:0] rhs_reg;
    logic          done_reg;
    logic          greater_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(MW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kl_reg  <= KL;
            kr_reg  <= KS * MW'(ratio);
            a_reg   <= PW'(st);
            b_reg   <= PW'(lt);
            lhs_reg <= '0;
            rhs_reg <= '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (kl_reg[0])
            begin
                lhs_reg <= lhs_reg + a_reg;
            end
            if (kr_reg[0])
            begin
                rhs_reg <= rhs_reg + b_reg;
            end
            kl_reg <= kl_reg >> 1;
            kr_reg <= kr_reg >> 1;
            a_reg  <= a_reg << 1;
            b_reg  <= b_reg << 1;
        end
        else if (busy_reg)
        begin
            greater_reg <= (lhs_reg > rhs_reg);
        end
    end

    assign done    = done_reg;
    assign greater = greater_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("ratio compare restarted while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("compare done without a finished pass");

endmodule

// ----- rtl/sta_lta_quake_trigger.sv -----
// Channel  | Dir | Handshake          | Payload
// in       | in  | in_valid/in_stall  | in_data  (quake_in_t)
// out      | out | out_valid/out_stall| out_data (quake_out_t)
// cfg      | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Until the ring is full a sample passes read old, write, then back to idle.
// A full-ring sample adds a scan of the whole ring, one ring read per cycle
// through the deviation unit, then the serial shift-add ratio compare when
// both sums are nonzero. in_stall is high from accept until done.
// A result waits in the output register; a new request is taken meanwhile.
// Reset clears pointer, fill count, window sum and hit count; no RAM sweep.
// Depends on slqt_pkg, slqt_ram, slqt_dev_acc, slqt_ratio_cmp.
module sta_lta_quake_trigger
    import slqt_pkg::*;
#(
    parameter int LONG_WINDOW  = 500,
    parameter int SHORT_WINDOW = 150
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  quake_in_t              in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output quake_out_t             out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SHORT_LEN = (SHORT_WINDOW < LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
    localparam int AW    = $clog2(LONG_WINDOW);
    localparam int CW    = $clog2(LONG_WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + CW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD_OLD = 3'd1;
    localparam logic [2:0] S_UPD    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_CMP    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]              state_reg, state_next;
    quake_in_t               item_reg;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [CW-1:0]           fill_count_reg, fill_count_next;
    logic signed [SUM_W-1:0] window_sum_reg, window_sum_next;
    logic [HIT_W-1:0]        hit_count_reg, hit_count_next;
    logic [AW-1:0]           rd_addr_reg, rd_addr_next;
    logic [CW-1:0]           issue_cnt_reg, issue_cnt_next;
    logic                    issue_vld_reg, issue_vld_next;
    logic                    issue_short_reg, issue_short_next;
    logic [RATIO_W-1:0]      ratio_q4_reg;
    logic [THR_W-1:0]        threshold_reg;
    logic                    out_valid_reg;
    quake_out_t              out_data_reg;

    logic                    full;
    logic                    in_take;
    logic                    out_load;
    logic [HIT_W-1:0]        hit_inc;
    logic signed [SUM_W-1:0] z_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic                    ram_we;
    logic [AW-1:0]           ram_rd_addr;
    logic [SAMPLE_W-1:0]     ram_rd_data;
    dev_ctrl_t               dev_ctrl;
    logic                    dev_busy;
    logic [DEV_SUM_W-1:0]    st_sum;
    logic [DEV_SUM_W-1:0]    lt_sum;
    logic                    cmp_start;
    logic                    cmp_done;
    logic                    cmp_greater;

    assign full      = (fill_count_reg == CW'(LONG_WINDOW));
    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign z_ext     = SUM_W'(item_reg.sample_z);
    assign old_ext   = {{(SUM_W-SAMPLE_W){ram_rd_data[SAMPLE_W-1]}}, ram_rd_data};
    assign hit_inc   = hit_count_reg + 1'b1;
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    assign ram_we      = (state_reg == S_UPD);
    assign ram_rd_addr = (state_reg == S_RD_OLD) ? wp_reg : rd_addr_reg;

    slqt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LONG_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (item_reg.sample_z),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign dev_ctrl.clear      = (state_reg == S_UPD);
    assign dev_ctrl.data_valid = issue_vld_reg;
    assign dev_ctrl.in_short   = issue_short_reg;

    slqt_dev_acc #(
        .LONG_WINDOW (LONG_WINDOW),
        .SUM_W       (SUM_W)
    ) u_dev (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dev_ctrl),
        .rd_data    (ram_rd_data),
        .window_sum (window_sum_reg),
        .busy       (dev_busy),
        .short_sum  (st_sum),
        .long_sum   (lt_sum)
    );

    assign cmp_start = (state_reg == S_CHECK) && (st_sum != '0) && (lt_sum != '0);

    slqt_ratio_cmp #(
        .LONG_WINDOW  (LONG_WINDOW),
        .SHORT_WINDOW (SHORT_WINDOW)
    ) u_cmp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmp_start),
        .st      (st_sum),
        .lt      (lt_sum),
        .ratio   (ratio_q4_reg),
        .done    (cmp_done),
        .greater (cmp_greater)
    );

    always_comb
    begin
        state_next       = state_reg;
        wp_next          = wp_reg;
        fill_count_next  = fill_count_reg;
        window_sum_next  = window_sum_reg;
        hit_count_next   = hit_count_reg;
        rd_addr_next     = rd_addr_reg;
        issue_cnt_next   = issue_cnt_reg;
        issue_vld_next   = 1'b0;
        issue_short_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_RD_OLD;
                end
            end
            S_RD_OLD:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                wp_next = (wp_reg == AW'(LONG_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                if (full)
                begin
                    window_sum_next = window_sum_reg - old_ext + z_ext;
                    rd_addr_next    = wp_reg;
                    issue_cnt_next  = '0;
                    state_next      = S_SCAN;
                end
                else
                begin
                    window_sum_next = window_sum_reg + z_ext;
                    fill_count_next = fill_count_reg + 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // newest entry first, so the short window is the first SHORT_LEN reads
                if (issue_cnt_reg != CW'(LONG_WINDOW))
                begin
                    issue_vld_next   = 1'b1;
                    issue_short_next = (issue_cnt_reg < CW'(SHORT_LEN));
                    issue_cnt_next   = issue_cnt_reg + 1'b1;
                    rd_addr_next     = (rd_addr_reg == '0) ? AW'(LONG_WINDOW - 1)
                                                           : rd_addr_reg - 1'b1;
                end
                else if (!issue_vld_reg && !dev_busy)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // a zero sum leaves the hit count alone
                state_next = cmp_start ? S_CMP : S_IDLE;
            end
            S_CMP:
            begin
                if (cmp_done)
                begin
                    if (!cmp_greater)
                    begin
                        hit_count_next = '0;
                        state_next     = S_IDLE;
                    end
                    else if (hit_inc > HIT_W'(threshold_reg))
                    begin
                        hit_count_next = '0;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        hit_count_next = hit_inc;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            wp_reg          <= '0;
            fill_count_reg  <= '0;
            window_sum_reg  <= '0;
            hit_count_reg   <= '0;
            rd_addr_reg     <= '0;
            issue_cnt_reg   <= '0;
            issue_vld_reg   <= 1'b0;
            issue_short_reg <= 1'b0;
            ratio_q4_reg    <= RATIO_Q4_RESET;
            threshold_reg   <= THRESHOLD_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wp_reg          <= wp_next;
            fill_count_reg  <= fill_count_next;
            window_sum_reg  <= window_sum_next;
            hit_count_reg   <= hit_count_next;
            rd_addr_reg     <= rd_addr_next;
            issue_cnt_reg   <= issue_cnt_next;
            issue_vld_reg   <= issue_vld_next;
            issue_short_reg <= issue_short_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RATIO_Q4)
                begin
                    ratio_q4_reg <= cfg_data[RATIO_W-1:0];
                end
                else if (cfg_index == REG_TRIGGER_THRESHOLD)
                begin
                    threshold_reg <= cfg_data[THR_W-1:0];
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
        end
        if (out_load)
        begin
            out_data_reg.event_time_ms <= item_reg.time_ms;
            out_data_reg.short_dev_sum <= st_sum;
            out_data_reg.long_dev_sum  <= lt_sum;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hit_count_reg <= HIT_W'(15))
        else $error("hit count past largest threshold");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CW'(LONG_WINDOW) && wp_reg <= AW'(LONG_WINDOW - 1))
        else $error("ring pointer or fill count out of range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    a_scan_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> full)
        else $error("deviation scan on a ring that is not full");

endmodule
